// ===== rtl/bod_pkg.sv =====
`default_nettype none
package bod_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_FACTOR = 15;
	localparam int POS_W      = $clog2(MAX_WIDTH);
	localparam int WIDTH_W    = 11;
	localparam int FACTOR_W   = 4;
	localparam int AGE_W      = 5;
	localparam int SPAN_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	typedef logic [AGE_W-1:0]    age_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [SPAN_W-1:0]   span_t;
	typedef logic [WIDTH_W-1:0]  width_t;
	typedef logic [FACTOR_W-1:0] factor_t;

	// no black seen yet
	localparam age_t AGE_NONE = age_t'(31);

	localparam width_t  ROW_WIDTH_RST = width_t'(640);
	localparam factor_t FACTOR_RST    = factor_t'(2);
	localparam width_t  WIDTH_MAX     = width_t'(MAX_WIDTH);
	localparam factor_t FACTOR_MAX    = factor_t'(MAX_FACTOR);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH = 1'b0,
		REG_INFLATE   = 1'b1
	} cfg_reg_t;

	// item handed to the compute stage on accept
	typedef struct packed {
		logic black;
		pos_t pos;
		logic last_col;
		logic row_start;
		logic fwd;
		age_t fwd_data;
	} load_t;

	// column age write from the compute stage
	typedef struct packed {
		logic en;
		pos_t addr;
		age_t data;
	} age_wr_t;

	function automatic age_t age_inc(input age_t a);
		return (a < AGE_NONE) ? age_t'(a + age_t'(1)) : AGE_NONE;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bod_if.sv =====
`default_nettype none
interface bod_pix_if;
	logic valid;
	logic ready;
	logic pixel_black;

	modport source(output valid, output pixel_black, input ready);
	modport sink(input valid, input pixel_black, output ready);
endinterface

interface bod_res_if;
	logic valid;
	logic ready;
	logic out_black;
	logic end_of_row;
	logic last_of_run;

	modport source(output valid, output out_black, output end_of_row, output last_of_run,
		input ready);
	modport sink(input valid, input out_black, input end_of_row, input last_of_run,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/bod_age_ram.sv =====
`default_nettype none
module bod_age_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 5,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bod_core.sv =====
`default_nettype none
module bod_core
	import bod_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire load_t   load_data,
	input  wire age_t    rdata,
	input  wire span_t   span,
	output logic         can_take,
	output age_wr_t      wr,
	bod_res_if.source    res
);

	logic  valid_s1;
	load_t ld_s1;
	span_t ph_q;
	age_t  hage_q;
	logic  out_valid_q;
	logic  out_black_q;
	logic  out_eor_q;
	logic  out_lor_q;

	logic  emit;
	logic  first;
	logic  done;
	age_t  age_rd;
	age_t  age_new;
	age_t  hage_base;
	age_t  hval;
	logic  eor;
	logic  lor;

	// column age and horizontal age for the current result
	always_comb begin
		first     = (ph_q == '0);
		age_rd    = ld_s1.fwd ? ld_s1.fwd_data : rdata;
		age_new   = ld_s1.black ? '0 : age_inc(age_rd);
		hage_base = ld_s1.row_start ? AGE_NONE : hage_q;
		if (first) begin
			hval = (age_new <= AGE_W'(span)) ? '0 : age_inc(hage_base);
			eor  = ld_s1.last_col && (span == '0);
			lor  = !ld_s1.last_col || (span == '0);
		end else begin
			hval = age_inc(hage_q);
			eor  = (ph_q == span);
			lor  = (ph_q == span);
		end
		done = lor;
	end

	// one result per cycle while the output slot frees up
	assign emit     = valid_s1 && (!out_valid_q || res.ready);
	assign can_take = !valid_s1 || (emit && done);

	// column age goes back with the first result
	always_comb begin
		wr.en   = emit && first;
		wr.addr = ld_s1.pos;
		wr.data = age_new;
	end

	// compute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ph_q     <= '0;
			hage_q   <= AGE_NONE;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (emit && done) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				hage_q <= hval;
				ph_q   <= done ? '0 : span_t'(ph_q + span_t'(1));
			end
		end
	end

	// compute stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			ld_s1 <= load_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_black_q <= (hval <= AGE_W'(span));
			out_eor_q   <= eor;
			out_lor_q   <= lor;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_black   = out_black_q;
	assign res.end_of_row  = out_eor_q;
	assign res.last_of_run = out_lor_q;

endmodule
`default_nettype wire

// ===== rtl/binary_obstacle_dilation.sv =====
`default_nettype none
// Binary obstacle dilation with a square kernel of side 2f+1. Source pixels
// come in raster order on pix, one per request; each yields one map pixel on
// res, and the last source pixel of a row yields 2f more padding pixels, so
// results run at one per cycle while res is ready, and input stalls at every
// row end while the padding goes out. A pixel goes through a registered column
// age read and one compute stage that feeds the output register; the column
// age store is a 1024 x 5 memory with one read and one write port. After
// reset the store is swept to "no black" before the first pixel is taken;
// configuration writes are taken during the sweep. Feed 2f white rows after
// a frame to flush its trailing rows and clear the store for the next one.
module binary_obstacle_dilation
	import bod_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	bod_pix_if.sink                    pix,
	bod_res_if.source                  res
);

	width_t      row_width_q;
	factor_t     factor_q;
	pos_t        pos_q;
	logic [POS_W:0] clr_cnt_q;

	logic    clr_done;
	logic    can_take;
	logic    accept;
	logic    last_col;
	width_t  w_eff;
	span_t   span;
	load_t   load_data;
	age_wr_t core_wr;
	age_t    rdata;
	logic    ram_we;
	pos_t    ram_waddr;
	age_t    ram_wdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
			factor_q    <= FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH: row_width_q <= cfg_data;
				REG_INFLATE:   factor_q    <= factor_t'(cfg_data[FACTOR_W-1:0]);
				default:       ;
			endcase
		end
	end

	// effective width and window span
	always_comb begin
		if (row_width_q == '0) begin
			w_eff = width_t'(1);
		end else if (row_width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = row_width_q;
		end
		span = (factor_q > FACTOR_MAX) ? {FACTOR_MAX, 1'b0} : {factor_q, 1'b0};
	end

	// store clear sweep after reset
	assign clr_done = clr_cnt_q[POS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (!clr_done) begin
			clr_cnt_q <= clr_cnt_q + (POS_W+1)'(1);
		end
	end

	// input handshake
	assign pix.ready = clr_done && can_take;
	assign accept    = pix.valid && pix.ready;
	assign last_col  = ({1'b0, pos_q} + width_t'(1)) >= w_eff;

	// column position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= last_col ? '0 : pos_t'(pos_q + pos_t'(1));
		end
	end

	// item for the compute stage, forwarding a same-column write
	always_comb begin
		load_data.black     = pix.pixel_black;
		load_data.pos       = pos_q;
		load_data.last_col  = last_col;
		load_data.row_start = (pos_q == '0);
		load_data.fwd       = core_wr.en && (core_wr.addr == pos_q);
		load_data.fwd_data  = core_wr.data;
	end

	// memory write port shared by the sweep and the compute stage
	always_comb begin
		if (!clr_done) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q[POS_W-1:0];
			ram_wdata = AGE_NONE;
		end else begin
			ram_we    = core_wr.en;
			ram_waddr = core_wr.addr;
			ram_wdata = core_wr.data;
		end
	end

	bod_age_ram #(
		.DEPTH(MAX_WIDTH),
		.DW   (AGE_W)
	) u_age_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(pos_q),
		.rdata(rdata)
	);

	bod_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.load_data(load_data),
		.rdata    (rdata),
		.span     (span),
		.can_take (can_take),
		.wr       (core_wr),
		.res      (res)
	);

endmodule
`default_nettype wire
